[rtl/dh_pkg.sv]
// Shared types and constants for the degree histogram.
`timescale 1ns / 1ps
`default_nettype none
package dh_pkg;

  localparam int DEF_BIN_COUNT   = 1024;
  localparam int DEF_COUNT_WIDTH = 20;

  localparam int DEGREE_W    = 10;
  localparam int OUT_COUNT_W = 20;
  localparam int SUM_W       = 30;
  localparam int FRAC_W      = 32;
  localparam int MEAN_W      = 26;
  localparam int Q_SHIFT     = 16;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_READ_BIN = 2'd1,
    CMD_READ_SUM = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

endpackage
`default_nettype wire

[rtl/dh_ram.sv]
// Generic single-clock RAM, one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module dh_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[rtl/dh_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module dh_div #(
  parameter int NUM_W = 46,
  parameter int DEN_W = 20
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic                  done,
  output logic      [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so it fits DEN_W bits.
      rem_nxt = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("divider done without a finished run");

endmodule
`default_nettype wire

[rtl/dh_stats.sv]
// Scalar accumulators: largest degree, sample counts, degree sum, range flag.
`timescale 1ns / 1ps
`default_nettype none
module dh_stats #(
  parameter int COUNT_WIDTH = dh_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         add,
  input  wire logic                         clear,
  input  wire logic [dh_pkg::DEGREE_W-1:0]  degree,
  input  wire logic                         beyond_bins,
  output logic      [dh_pkg::DEGREE_W-1:0]  largest,
  output logic      [COUNT_WIDTH-1:0]       nonzero_cnt,
  output logic      [COUNT_WIDTH-1:0]       total_cnt,
  output logic      [dh_pkg::SUM_W-1:0]     degree_sum,
  output logic                              range_seen
);
  import dh_pkg::*;

  logic [DEGREE_W-1:0]    largest_r, largest_nxt;
  logic [COUNT_WIDTH-1:0] nonzero_r, nonzero_nxt;
  logic [COUNT_WIDTH-1:0] total_r, total_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic                   range_r, range_nxt;
  logic [SUM_W:0]         sum_wide;

  assign sum_wide = {1'b0, sum_r} + (SUM_W + 1)'(degree);

  always_comb begin
    largest_nxt = largest_r;
    nonzero_nxt = nonzero_r;
    total_nxt   = total_r;
    sum_nxt     = sum_r;
    range_nxt   = range_r;
    if (clear) begin
      largest_nxt = '0;
      nonzero_nxt = '0;
      total_nxt   = '0;
      sum_nxt     = '0;
      range_nxt   = 1'b0;
    end else if (add) begin
      if (degree > largest_r) begin
        largest_nxt = degree;
      end
      if ((degree != '0) && !(&nonzero_r)) begin
        nonzero_nxt = nonzero_r + COUNT_WIDTH'(1);
      end
      if (!(&total_r)) begin
        total_nxt = total_r + COUNT_WIDTH'(1);
      end
      // The degree sum sticks at its largest value instead of wrapping.
      sum_nxt = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      if (beyond_bins) begin
        range_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      largest_r <= '0;
      nonzero_r <= '0;
      total_r   <= '0;
      sum_r     <= '0;
      range_r   <= 1'b0;
    end else begin
      largest_r <= largest_nxt;
      nonzero_r <= nonzero_nxt;
      total_r   <= total_nxt;
      sum_r     <= sum_nxt;
      range_r   <= range_nxt;
    end
  end

  assign largest     = largest_r;
  assign nonzero_cnt = nonzero_r;
  assign total_cnt   = total_r;
  assign degree_sum  = sum_r;
  assign range_seen  = range_r;

endmodule
`default_nettype wire

[rtl/degree_histogram.sv]
// Degree histogram top level: bin memory pipeline, read sequencer and outputs.
//
// Usage: each item on the in_ channel is a command. Add sample counts
// in_sample_degree into its bin (degrees at or beyond BIN_COUNT go to the top
// bin and set the range flag); clear all zeroes every bin and statistic.
// Neither returns an item. Read bin and read summary each return one item on
// the out_ channel carrying the running totals plus either the bin count and
// its Q16.16 share of the nonzero samples, or the two Q10.16 mean degrees.
// Throughput: adds are taken one per cycle while in_ready is high; the bin
// memory is read as an add is taken and written back from the pipeline register,
// with forwarding between back-to-back adds to the same bin. A read bin runs one
// division on the shared bit-serial divider and a read summary runs two, each of
// NUM_W = max(COUNT_WIDTH, 30) + 16 (46 by default) quotient bits; in_ready stays
// low while a read is in progress. A clear all, and reset, start a clearing pass
// that writes zero to every bin address in turn with in_ready low.
// The result sits in an output register; while the receiver stalls, adds keep
// flowing and a later read waits in the sequencer until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module degree_histogram #(
  parameter int BIN_COUNT   = dh_pkg::DEF_BIN_COUNT,
  parameter int COUNT_WIDTH = dh_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_command,
  input  wire logic [dh_pkg::DEGREE_W-1:0]    in_sample_degree,
  input  wire logic [dh_pkg::DEGREE_W-1:0]    in_bin_index,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [dh_pkg::OUT_COUNT_W-1:0] out_bin_count,
  output logic      [dh_pkg::FRAC_W-1:0]      out_bin_fraction,
  output logic      [dh_pkg::OUT_COUNT_W-1:0] out_total_samples,
  output logic      [dh_pkg::OUT_COUNT_W-1:0] out_nonzero_samples,
  output logic      [dh_pkg::DEGREE_W-1:0]    out_largest_degree,
  output logic      [dh_pkg::MEAN_W-1:0]      out_mean_nonzero,
  output logic      [dh_pkg::MEAN_W-1:0]      out_mean_all,
  output logic                                out_range_flag
);
  import dh_pkg::*;

  localparam int IDX_W = $clog2(BIN_COUNT);
  localparam int NUM_W = ((COUNT_WIDTH > SUM_W) ? COUNT_WIDTH : SUM_W) + Q_SHIFT;
  localparam int EXT_W = (COUNT_WIDTH > OUT_COUNT_W) ? COUNT_WIDTH : OUT_COUNT_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_RUN   = 5'b00010,
    S_DIV_A = 5'b00100,
    S_DIV_B = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t st_r, st_nxt;
  logic [IDX_W-1:0] clr_addr_r, clr_addr_nxt;

  // Input decode.
  cmd_t             in_cmd;
  logic             in_fire;
  logic [31:0]      deg_ext, idx_ext;
  logic             deg_oob, idx_oob;
  logic [IDX_W-1:0] add_addr, idx_addr;

  // Second stage of the bin pipeline.
  logic             p_valid_r, p_valid_nxt;
  cmd_t             p_cmd_r;
  logic [IDX_W-1:0] p_addr_r;
  logic             p_oob_r;
  logic             p_rd;

  // Bin memory and write forwarding.
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr, ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;
  logic                   fwd_valid_r;
  logic [IDX_W-1:0]       fwd_addr_r;
  logic [COUNT_WIDTH-1:0] fwd_data_r;
  logic [COUNT_WIDTH-1:0] bin_val, bin_bumped;

  // Statistics.
  logic [DEGREE_W-1:0]    largest;
  logic [COUNT_WIDTH-1:0] nonzero_cnt, total_cnt;
  logic [SUM_W-1:0]       degree_sum;
  logic                   range_seen;

  // Read sequencer and divider.
  logic                   rd_bin_r, rd_bin_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [FRAC_W-1:0]      frac_r, frac_nxt;
  logic [MEAN_W-1:0]      mnz_r, mnz_nxt;
  logic [MEAN_W-1:0]      mall_r, mall_nxt;
  logic                   div_start, div_busy, div_done;
  logic [NUM_W-1:0]       div_num, div_quo;
  logic [COUNT_WIDTH-1:0] div_den;
  logic [FRAC_W-1:0]      quo_frac;
  logic [MEAN_W-1:0]      quo_mean;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_load;
  logic [EXT_W-1:0]       cnt_ext, total_ext, nonzero_ext;
  logic [OUT_COUNT_W-1:0] out_bin_count_r, out_total_r, out_nonzero_r;
  logic [FRAC_W-1:0]      out_frac_r;
  logic [DEGREE_W-1:0]    out_largest_r;
  logic [MEAN_W-1:0]      out_mnz_r, out_mall_r;
  logic                   out_range_r;

  assign in_cmd   = cmd_t'(in_command);
  assign p_rd     = p_valid_r && ((p_cmd_r == CMD_READ_BIN) || (p_cmd_r == CMD_READ_SUM));
  assign in_ready = (st_r == S_RUN) && !p_rd;
  assign in_fire  = in_valid && in_ready;

  assign deg_ext  = 32'(in_sample_degree);
  assign idx_ext  = 32'(in_bin_index);
  assign deg_oob  = deg_ext >= 32'(BIN_COUNT);
  assign idx_oob  = idx_ext >= 32'(BIN_COUNT);
  assign add_addr = deg_oob ? IDX_W'(BIN_COUNT - 1) : deg_ext[IDX_W-1:0];
  assign idx_addr = idx_ext[IDX_W-1:0];
  assign ram_raddr = (in_cmd == CMD_ADD) ? add_addr : idx_addr;

  // An add written in the previous cycle is not yet visible in the read data.
  assign bin_val    = (fwd_valid_r && (fwd_addr_r == p_addr_r)) ? fwd_data_r : ram_rdata;
  assign bin_bumped = (&bin_val) ? bin_val : bin_val + COUNT_WIDTH'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p_addr_r;
    ram_wdata = bin_bumped;
    if (st_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (p_valid_r && (p_cmd_r == CMD_ADD)) begin
      ram_we = 1'b1;
    end
  end

  dh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (BIN_COUNT)
  ) u_bins (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  dh_stats #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_stats (
    .clk         (clk),
    .rst_n       (rst_n),
    .add         (in_fire && (in_cmd == CMD_ADD)),
    .clear       (in_fire && (in_cmd == CMD_CLEAR)),
    .degree      (in_sample_degree),
    .beyond_bins (deg_oob),
    .largest     (largest),
    .nonzero_cnt (nonzero_cnt),
    .total_cnt   (total_cnt),
    .degree_sum  (degree_sum),
    .range_seen  (range_seen)
  );

  dh_div #(
    .NUM_W (NUM_W),
    .DEN_W (COUNT_WIDTH)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Quotients above the field range saturate.
  assign quo_frac = (|div_quo[NUM_W-1:FRAC_W]) ? '1 : div_quo[FRAC_W-1:0];
  assign quo_mean = (|div_quo[NUM_W-1:MEAN_W]) ? '1 : div_quo[MEAN_W-1:0];

  assign out_load = !out_valid_r || out_ready;

  always_comb begin
    st_nxt       = st_r;
    clr_addr_nxt = clr_addr_r;
    p_valid_nxt  = in_fire && (in_cmd != CMD_CLEAR);
    rd_bin_nxt   = rd_bin_r;
    cnt_nxt      = cnt_r;
    frac_nxt     = frac_r;
    mnz_nxt      = mnz_r;
    mall_nxt     = mall_r;
    div_start    = 1'b0;
    div_num      = NUM_W'({degree_sum, Q_SHIFT'(0)});
    div_den      = nonzero_cnt;
    unique case (st_r)
      S_CLEAR: begin
        if (clr_addr_r == IDX_W'(BIN_COUNT - 1)) begin
          clr_addr_nxt = '0;
          st_nxt       = S_RUN;
        end else begin
          clr_addr_nxt = clr_addr_r + IDX_W'(1);
        end
      end
      S_RUN: begin
        if (in_fire && (in_cmd == CMD_CLEAR)) begin
          st_nxt = S_CLEAR;
        end else if (p_rd) begin
          div_start = 1'b1;
          st_nxt    = S_DIV_A;
          mnz_nxt   = '0;
          mall_nxt  = '0;
          frac_nxt  = '0;
          if (p_cmd_r == CMD_READ_BIN) begin
            rd_bin_nxt = 1'b1;
            cnt_nxt    = p_oob_r ? '0 : bin_val;
            div_num    = NUM_W'({(p_oob_r ? '0 : bin_val), Q_SHIFT'(0)});
          end else begin
            rd_bin_nxt = 1'b0;
            cnt_nxt    = '0;
          end
        end
      end
      S_DIV_A: begin
        if (div_done) begin
          if (rd_bin_r) begin
            frac_nxt = (nonzero_cnt == '0) ? '0 : quo_frac;
            st_nxt   = S_OUT;
          end else begin
            mnz_nxt   = (nonzero_cnt == '0) ? '0 : quo_mean;
            div_start = 1'b1;
            div_den   = total_cnt;
            st_nxt    = S_DIV_B;
          end
        end
      end
      S_DIV_B: begin
        if (div_done) begin
          mall_nxt = (total_cnt == '0) ? '0 : quo_mean;
          st_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          st_nxt = S_RUN;
        end
      end
      default: begin
        st_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if ((st_r == S_OUT) && out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      clr_addr_r  <= '0;
      p_valid_r   <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_addr_r  <= clr_addr_nxt;
      p_valid_r   <= p_valid_nxt;
      fwd_valid_r <= ram_we;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cnt_ext     = EXT_W'(cnt_r);
  assign total_ext   = EXT_W'(total_cnt);
  assign nonzero_ext = EXT_W'(nonzero_cnt);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p_cmd_r  <= in_cmd;
      p_addr_r <= ram_raddr;
      p_oob_r  <= idx_oob;
    end
    fwd_addr_r <= ram_waddr;
    fwd_data_r <= ram_wdata;
    rd_bin_r   <= rd_bin_nxt;
    cnt_r      <= cnt_nxt;
    frac_r     <= frac_nxt;
    mnz_r      <= mnz_nxt;
    mall_r     <= mall_nxt;
    if ((st_r == S_OUT) && out_load) begin
      out_bin_count_r <= cnt_ext[OUT_COUNT_W-1:0];
      out_frac_r      <= frac_r;
      out_total_r     <= total_ext[OUT_COUNT_W-1:0];
      out_nonzero_r   <= nonzero_ext[OUT_COUNT_W-1:0];
      out_largest_r   <= largest;
      out_mnz_r       <= mnz_r;
      out_mall_r      <= mall_r;
      out_range_r     <= range_seen;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_bin_count       = out_bin_count_r;
  assign out_bin_fraction    = out_frac_r;
  assign out_total_samples   = out_total_r;
  assign out_nonzero_samples = out_nonzero_r;
  assign out_largest_degree  = out_largest_r;
  assign out_mean_nonzero    = out_mnz_r;
  assign out_mean_all        = out_mall_r;
  assign out_range_flag      = out_range_r;

  a_sweep_no_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLEAR) |-> !p_valid_r)
    else $error("bin pipeline active during the clearing pass");

  a_read_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == S_RUN) && p_rd) |=> ((st_r == S_DIV_A) && div_busy))
    else $error("read did not start the divider");

  a_out_fields_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (((out_mnz_r == '0) && (out_mall_r == '0)) ||
                     ((out_bin_count_r == '0) && (out_frac_r == '0))))
    else $error("bin and summary fields both set in one item");

endmodule
`default_nettype wire
